// ===== hw/rtl/tap_pkg.sv =====
package tap_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int EXTENT_BITS     = 12;
   localparam int VALUE_BITS      = 64;
   localparam int INDEX_BITS      = 48;
   localparam int COUNT_BITS      = 3;
   localparam int AXIS_BITS       = 3;
   localparam int AXIS_ORDER_BITS = 4 * AXIS_BITS;
   localparam int DIM_BITS        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PROD_BITS       = MAX_DIMS * EXTENT_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   =
      (EXTENT_BITS > AXIS_ORDER_BITS) ? EXTENT_BITS : AXIS_ORDER_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DIM_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_0   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_ORDER = 3'd5;

   localparam logic [COUNT_BITS-1:0]      DIM_COUNT_RESET  = 3'd1;
   localparam logic [EXTENT_BITS-1:0]     EXTENT_RESET     = EXTENT_BITS'(1);
   localparam logic [AXIS_ORDER_BITS-1:0] AXIS_ORDER_RESET = 12'd1672;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DIM_ZERO   = 2'd1,
      ST_AXIS_RANGE = 2'd2,
      ST_DUP_AXIS   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      DRV_IDLE,
      DRV_START,
      DRV_SRC,
      DRV_DST,
      DRV_CHECK,
      DRV_WRAP,
      DRV_DELTA
   } derive_state_type;

   typedef struct packed {
      logic                                   busy;
      logic                                   restart;
      status_type                             status;
      logic                                   empty;
      logic [COUNT_BITS-1:0]                  dims;
      logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]   extent;
      logic [MAX_DIMS-1:0][INDEX_BITS-1:0]    delta;
   } tap_cfg_type;

endpackage

// ===== hw/rtl/tap_req_if.sv =====
interface tap_req_if;
   import tap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] in_value;

   modport source(output valid, output in_value, input ready);
   modport sink(input valid, input in_value, output ready);

endinterface

// ===== hw/rtl/tap_rsp_if.sv =====
interface tap_rsp_if;
   import tap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] out_value;
   logic [INDEX_BITS-1:0] dest_index;
   logic [1:0]            status;
   logic                  last;

   modport source(output valid, output out_value, output dest_index, output status,
                  output last, input ready);
   modport sink(input valid, input out_value, input dest_index, input status,
                input last, output ready);

endinterface

// ===== hw/rtl/tap_derive.sv =====
module tap_derive (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tap_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tap_pkg::CSR_DATA_BITS-1:0]     csr_wr_data,
   output tap_pkg::tap_cfg_type                  cfg
);
   import tap_pkg::*;

   logic [COUNT_BITS-1:0]                dim_count_ff;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] extent_ff;
   logic [AXIS_ORDER_BITS-1:0]           axis_order_ff;

   derive_state_type                     state_ff, state_in;
   logic [DIM_BITS-1:0]                  idx_ff, idx_in;
   logic [PROD_BITS-1:0]                 src_ff, src_in;
   logic [PROD_BITS-1:0]                 dst_ff, dst_in;
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0]  stride_ff, stride_in;
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0]  delta_ff, delta_in;
   logic [INDEX_BITS-1:0]                acc_ff, acc_in;
   logic [INDEX_BITS-1:0]                prod_ff, prod_in;
   status_type                           status_ff, status_in;
   logic                                 empty_ff, empty_in;

   logic                                 write_hit;
   logic [COUNT_BITS-1:0]                dims;
   logic [AXIS_BITS-1:0]                 target;
   logic [DIM_BITS-1:0]                  rd_sel;
   logic [EXTENT_BITS-1:0]               ext_rd;
   logic [EXTENT_BITS-1:0]               ext_less_one;

   assign write_hit = csr_wr_en && (csr_index <= REG_AXIS_ORDER);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff  <= DIM_COUNT_RESET;
         axis_order_ff <= AXIS_ORDER_RESET;
         for (int k = 0; k < MAX_DIMS; k++) begin
            extent_ff[k] <= EXTENT_RESET;
         end
      end else if (csr_wr_en) begin
         if (csr_index == REG_DIM_COUNT) begin
            dim_count_ff <= csr_wr_data[COUNT_BITS-1:0];
         end
         if (csr_index == REG_AXIS_ORDER) begin
            axis_order_ff <= csr_wr_data[AXIS_ORDER_BITS-1:0];
         end
         for (int k = 0; k < MAX_DIMS; k++) begin
            if (csr_index == REG_EXTENT_0 + CSR_INDEX_BITS'(k)) begin
               extent_ff[k] <= csr_wr_data[EXTENT_BITS-1:0];
            end
         end
      end
   end

   assign dims = (dim_count_ff > COUNT_BITS'(MAX_DIMS)) ? COUNT_BITS'(MAX_DIMS) : dim_count_ff;
   assign target = axis_order_ff[AXIS_BITS*idx_ff +: AXIS_BITS];
   assign rd_sel = (state_ff == DRV_DST) ? target[DIM_BITS-1:0] : idx_ff;
   assign ext_rd = extent_ff[rd_sel];
   assign ext_less_one = ext_rd - EXTENT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= DRV_START;
         status_ff <= ST_OK;
         empty_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         empty_ff  <= empty_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      stride_ff <= stride_in;
      delta_ff  <= delta_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      stride_in = stride_ff;
      delta_in  = delta_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      empty_in  = empty_ff;
      case (state_ff)
         DRV_IDLE: begin
         end
         DRV_START: begin
            src_in    = PROD_BITS'(1);
            dst_in    = PROD_BITS'(1);
            stride_in = '0;
            delta_in  = '0;
            empty_in  = 1'b0;
            idx_in    = DIM_BITS'(dims - COUNT_BITS'(1));
            if (dims == '0) begin
               status_in = ST_DIM_ZERO;
               state_in  = DRV_IDLE;
            end else begin
               status_in = ST_OK;
               state_in  = DRV_SRC;
            end
         end
         DRV_SRC: begin
            src_in = PROD_BITS'(src_ff * ext_rd);
            if (COUNT_BITS'(target) >= dims) begin
               status_in = ST_AXIS_RANGE;
               state_in  = DRV_IDLE;
            end else begin
               state_in = DRV_DST;
            end
         end
         DRV_DST: begin
            stride_in[target[DIM_BITS-1:0]] = INDEX_BITS'(dst_ff);
            dst_in = PROD_BITS'(dst_ff * ext_rd);
            if (idx_ff == '0) begin
               state_in = DRV_CHECK;
            end else begin
               idx_in   = idx_ff - DIM_BITS'(1);
               state_in = DRV_SRC;
            end
         end
         DRV_CHECK: begin
            idx_in = DIM_BITS'(dims - COUNT_BITS'(1));
            acc_in = '0;
            if (src_ff != dst_ff) begin
               status_in = ST_DUP_AXIS;
               state_in  = DRV_IDLE;
            end else begin
               empty_in = (src_ff == '0);
               state_in = DRV_WRAP;
            end
         end
         // span of a full wrap of one dimension
         DRV_WRAP: begin
            prod_in  = INDEX_BITS'(ext_less_one) * stride_ff[idx_ff];
            state_in = DRV_DELTA;
         end
         // step into dimension idx after all inner ones wrap
         DRV_DELTA: begin
            delta_in[idx_ff] = stride_ff[idx_ff] - acc_ff;
            acc_in = acc_ff + prod_ff;
            if (idx_ff == '0) begin
               state_in = DRV_IDLE;
            end else begin
               idx_in   = idx_ff - DIM_BITS'(1);
               state_in = DRV_WRAP;
            end
         end
         default: begin
            state_in = DRV_START;
         end
      endcase
      if (write_hit) begin
         state_in = DRV_START;
      end
   end

   assign cfg.busy    = (state_ff != DRV_IDLE) || csr_wr_en;
   assign cfg.restart = (state_ff == DRV_START);
   assign cfg.status  = status_ff;
   assign cfg.empty   = empty_ff;
   assign cfg.dims    = dims;
   assign cfg.extent  = extent_ff;
   assign cfg.delta   = delta_ff;

endmodule

// ===== hw/rtl/tap_step.sv =====
module tap_step (
   input  logic                 clock,
   input  logic                 reset,
   input  tap_pkg::tap_cfg_type cfg,
   tap_req_if.sink              req_chan,
   tap_rsp_if.source            rsp_chan
);
   import tap_pkg::*;

   logic                                 s1_valid_ff;
   logic [VALUE_BITS-1:0]                s1_value_ff;
   logic                                 rsp_valid_ff;
   logic [VALUE_BITS-1:0]                rsp_value_ff;
   logic [INDEX_BITS-1:0]                rsp_index_ff;
   status_type                           rsp_status_ff;
   logic                                 rsp_last_ff;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0]                accum_ff, accum_in;

   logic                                 cfg_ok;
   logic                                 s1_drop;
   logic                                 out_free;
   logic                                 s1_fire;
   logic                                 s1_leave;
   logic                                 req_fire;
   logic                                 found;
   logic [DIM_BITS-1:0]                  sel;

   assign cfg_ok   = (cfg.status == ST_OK);
   assign s1_drop  = s1_valid_ff && cfg_ok && cfg.empty;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire  = s1_valid_ff && !s1_drop && out_free;
   assign s1_leave = s1_fire || s1_drop;
   assign req_chan.ready = !cfg.busy && (!s1_valid_ff || s1_leave);
   assign req_fire = req_chan.valid && req_chan.ready;

   // innermost dimension that can still count up
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if ((COUNT_BITS'(k) < cfg.dims) &&
             (({1'b0, pos_ff[k]} + 1'b1) < {1'b0, cfg.extent[k]})) begin
            found = 1'b1;
            sel   = DIM_BITS'(k);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (found && (DIM_BITS'(k) == sel)) begin
            pos_in[k] = pos_ff[k] + EXTENT_BITS'(1);
         end else if (found && (DIM_BITS'(k) < sel)) begin
            pos_in[k] = pos_ff[k];
         end else begin
            pos_in[k] = '0;
         end
      end
      accum_in = found ? (accum_ff + cfg.delta[sel]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         pos_ff   <= '0;
         accum_ff <= '0;
      end else if (s1_fire && cfg_ok) begin
         pos_ff   <= pos_in;
         accum_ff <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_leave) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_value_ff <= req_chan.in_value;
      end
      if (s1_fire) begin
         rsp_value_ff  <= s1_value_ff;
         rsp_status_ff <= cfg.status;
         rsp_index_ff  <= cfg_ok ? accum_ff : '0;
         rsp_last_ff   <= cfg_ok && !found;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_value  = rsp_value_ff;
   assign rsp_chan.dest_index = rsp_index_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule

// ===== hw/rtl/tensor_axis_permute.sv =====
// streaming axis permutation of a tensor of up to four dimensions
// req_chan: one source element per transfer, in row-major source order
// rsp_chan: the same element with its linear index in the permuted tensor,
//    a status code and a flag on the final element of the tensor
// csr port: write enable, register index and data; registers 0 to 5 are
//    dim_count, extent_0 to extent_3 and axis_order, no read-back
// every register write recomputes the strides and restarts the position
//    counter, with req_chan not ready meanwhile; reset runs the same pass
//    on the reset values
// two register stages: the input register and the result register
// throughput: one element per cycle while the receiver takes results and no register write is pending
// a stalled receiver holds the result register; one more element waits
//    in the input register; outside a register write, req_chan ready drops only when both are full
// a bad configuration gives index zero with an error status for every
//    element; an empty tensor drops its elements without a result
module tensor_axis_permute (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [tap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tap_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   tap_req_if.sink                            req_chan,
   tap_rsp_if.source                          rsp_chan
);
   import tap_pkg::*;

   tap_cfg_type cfg;

   tap_derive u_derive (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tap_step u_step (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== bench/permute_index_checker.sv =====
module permute_index_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [tap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tap_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   tap_req_if                                 req_tap,
   tap_rsp_if                                 rsp_tap,
   output int unsigned                        mismatches,
   output int unsigned                        elems_predicted,
   output int unsigned                        elems_outstanding
);
   import tap_pkg::*;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0] index;
      status_type            status;
      logic                  last;
   } permuted_elem_type;

   logic [COUNT_BITS-1:0]      dims_reg;
   logic [EXTENT_BITS-1:0]     extent_reg [MAX_DIMS];
   logic [AXIS_ORDER_BITS-1:0] order_reg;

   int unsigned                dims_used;
   logic [EXTENT_BITS-1:0]     position [MAX_DIMS];
   logic [INDEX_BITS-1:0]      stride [MAX_DIMS];
   logic [INDEX_BITS-1:0]      dest_accum;
   status_type                 layout_status;
   bit                         layout_empty;

   permuted_elem_type          pending_elems [$];
   int unsigned                fail_count = 0;
   int unsigned                predicted = 0;

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 30) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   // destination strides from extents and axis order, counter back to zero
   function automatic void derive_layout();
      longint unsigned src_elems;
      longint unsigned dst_elems;
      int              target;
      dims_used = (dims_reg > MAX_DIMS) ? MAX_DIMS : dims_reg;
      for (int k = 0; k < MAX_DIMS; k++) begin
         position[k] = '0;
         stride[k]   = '0;
      end
      dest_accum    = '0;
      layout_status = ST_OK;
      layout_empty  = 1'b0;
      if (dims_used == 0) begin
         layout_status = ST_DIM_ZERO;
         return;
      end
      src_elems = 1;
      dst_elems = 1;
      for (int i = int'(dims_used) - 1; i >= 0; i--) begin
         target = int'(order_reg[AXIS_BITS*i +: AXIS_BITS]);
         src_elems *= extent_reg[i];
         if (target >= int'(dims_used)) begin
            layout_status = ST_AXIS_RANGE;
            return;
         end
         stride[target] = dst_elems[INDEX_BITS-1:0];
         dst_elems *= extent_reg[target];
      end
      if (src_elems != dst_elems) begin
         layout_status = ST_DUP_AXIS;
         return;
      end
      layout_empty = (src_elems == 0);
   endfunction

   // returns 0 when the element of an empty tensor is dropped
   function automatic bit permute_step(input logic [VALUE_BITS-1:0] elem,
                                       output permuted_elem_type res);
      bit wrapped;
      wrapped    = 1'b1;
      res.value  = elem;
      res.index  = '0;
      res.status = layout_status;
      res.last   = 1'b0;
      if (layout_status != ST_OK) return 1'b1;
      if (layout_empty) return 1'b0;
      res.index = dest_accum;
      for (int k = int'(dims_used) - 1; k >= 0; k--) begin
         if (int'(position[k]) + 1 < int'(extent_reg[k])) begin
            position[k] = position[k] + 1'b1;
            dest_accum  = dest_accum + stride[k];
            wrapped     = 1'b0;
            break;
         end
         dest_accum  = dest_accum - position[k] * stride[k];
         position[k] = '0;
      end
      if (wrapped) dest_accum = '0;
      res.last = wrapped;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : track
      permuted_elem_type want;
      bit                mapped;
      if (reset) begin
         dims_reg = DIM_COUNT_RESET;
         foreach (extent_reg[k]) extent_reg[k] = EXTENT_RESET;
         order_reg = AXIS_ORDER_RESET;
         derive_layout();
         pending_elems.delete();
      end else begin
         if (csr_wr_en) begin
            mapped = 1'b1;
            if (csr_index == REG_DIM_COUNT) begin
               dims_reg = csr_wr_data[COUNT_BITS-1:0];
            end else if (csr_index >= REG_EXTENT_0 && csr_index < REG_EXTENT_0 + MAX_DIMS) begin
               extent_reg[DIM_BITS'(csr_index - REG_EXTENT_0)] = csr_wr_data[EXTENT_BITS-1:0];
            end else if (csr_index == REG_AXIS_ORDER) begin
               order_reg = csr_wr_data[AXIS_ORDER_BITS-1:0];
            end else begin
               mapped = 1'b0;
            end
            if (mapped) derive_layout();
         end
         if (req_tap.valid && req_tap.ready) begin
            if (permute_step(req_tap.in_value, want)) begin
               pending_elems.push_back(want);
               predicted++;
            end
         end
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (pending_elems.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer value %h index %0d status %0d",
                                         rsp_tap.out_value, rsp_tap.dest_index, rsp_tap.status));
            end else begin
               want = pending_elems.pop_front();
               if (rsp_tap.out_value !== want.value || rsp_tap.dest_index !== want.index ||
                   rsp_tap.status !== want.status || rsp_tap.last !== want.last) begin
                  report_mismatch($sformatf(
                     "value %h/%h index %0d/%0d status %0d/%0d last %b/%b (got/exp)",
                     rsp_tap.out_value, want.value, rsp_tap.dest_index, want.index,
                     rsp_tap.status, want.status, rsp_tap.last, want.last));
               end
            end
         end
      end
      mismatches        <= fail_count;
      elems_predicted   <= predicted;
      elems_outstanding <= pending_elems.size();
   end

endmodule

// ===== bench/tensor_axis_permute_tb.sv =====
module tensor_axis_permute_tb;
   import tap_pkg::*;

   localparam int ELEM_TARGET   = 1150;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;

   typedef enum {
      DRAIN_FREE,
      DRAIN_PATCHY,
      DRAIN_SPARSE_STALL,
      DRAIN_STARVED
   } drain_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;

   int unsigned               mismatches;
   int unsigned               elems_predicted;
   int unsigned               elems_outstanding;
   int unsigned               quiet_cycles = 0;
   int unsigned               drain_run = 0;
   drain_mode_type            drain_mode = DRAIN_FREE;
   int unsigned               layouts_applied = 0;
   int unsigned               elems_sent = 0;

   tap_req_if req_chan();
   tap_rsp_if rsp_chan();

   tensor_axis_permute i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   permute_index_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_tap           (req_chan),
      .rsp_tap           (rsp_chan),
      .mismatches        (mismatches),
      .elems_predicted   (elems_predicted),
      .elems_outstanding (elems_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, changing its character every so often
   always @(posedge clock) begin
      if (drain_run == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         drain_run  <= $urandom_range(16, 160);
      end else begin
         drain_run <= drain_run - 1;
      end
      case (drain_mode)
         DRAIN_FREE:         rsp_chan.ready <= 1'b1;
         DRAIN_PATCHY:       rsp_chan.ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE_STALL: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         default:            rsp_chan.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stalled after %0d elements sent and %0d results predicted",
                  elems_sent, elems_predicted);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      do @(posedge clock); while (elems_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_layout(input logic [COUNT_BITS-1:0] dims,
                                 input logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] ext,
                                 input logic [AXIS_ORDER_BITS-1:0] order);
      logic [CSR_DATA_BITS-1:0] dim_word;
      wait_idle();
      dim_word                   = CSR_DATA_BITS'($urandom);
      dim_word[COUNT_BITS-1:0]   = dims;
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_DIM_COUNT;
      csr_wr_data <= dim_word;
      @(posedge clock);
      for (int k = 0; k < MAX_DIMS; k++) begin
         csr_index   <= CSR_INDEX_BITS'(REG_EXTENT_0 + k);
         csr_wr_data <= ext[k];
         @(posedge clock);
      end
      csr_index   <= REG_AXIS_ORDER;
      csr_wr_data <= order;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      layouts_applied++;
   endtask

   // bursts of random length with random gaps between them
   task automatic send_elems(input int count);
      int                    sent;
      int                    burst;
      int                    gap;
      logic [VALUE_BITS-1:0] elem;
      sent = 0;
      while (sent < count) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst = $urandom_range(1, 24);
         while (burst != 0 && sent < count) begin
            case ($urandom_range(0, 9))
               0:       elem = '0;
               1:       elem = '1;
               default: elem = {$urandom, $urandom};
            endcase
            if (elems_sent == 0) elem = '0;
            else if (elems_sent == 1) elem = '1;
            req_chan.valid    <= 1'b1;
            req_chan.in_value <= elem;
            do @(posedge clock); while (!req_chan.ready);
            burst--;
            sent++;
            elems_sent++;
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      logic [COUNT_BITS-1:0]                dims;
      logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] ext;
      logic [AXIS_ORDER_BITS-1:0]           order;
      int                                   axis_of [MAX_DIMS];
      int                                   roll;
      int                                   n_used;
      int                                   pick;
      int                                   other;
      int                                   tmp;
      int                                   n_elems;
      longint unsigned                      volume;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= '0;
      csr_wr_data       <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.in_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset layout: one-element tensor
      send_elems(3);
      // dimension count zero
      program_layout(3'd0, {4{12'hFFF}}, 12'h000);
      send_elems(2);
      // single axis, all axis fields zero
      program_layout(3'd1, {12'd1, 12'd1, 12'd1, 12'd3}, 12'h000);
      send_elems(4);
      // every axis field out of range
      program_layout(3'd2, {12'd1, 12'd1, 12'd3, 12'd2}, 12'hFFF);
      send_elems(2);
      // duplicate axis with unequal element products
      program_layout(3'd2, {12'd1, 12'd1, 12'd3, 12'd2}, {6'd0, 3'd0, 3'd0});
      send_elems(2);
      // duplicate axis with equal products: passes with a zero stride
      program_layout(3'd2, {12'd1, 12'd1, 12'd3, 12'd3}, {6'd0, 3'd1, 3'd1});
      send_elems(4);
      // empty tensor drops its elements
      program_layout(3'd2, {12'd1, 12'd1, 12'd3, 12'd0}, {6'd0, 3'd1, 3'd0});
      send_elems(3);
      // plain 2x3 transpose with wrap
      program_layout(3'd2, {12'd1, 12'd1, 12'd3, 12'd2}, {6'd0, 3'd0, 3'd1});
      send_elems(6);
      // count above the maximum, full extents, reversed axes
      program_layout(3'd7, {4{12'hFFF}}, {3'd0, 3'd1, 3'd2, 3'd3});
      send_elems(3);

      while (elems_predicted < ELEM_TARGET) begin
         roll   = $urandom_range(0, 99);
         n_used = (roll >= 6 && roll < 12) ? MAX_DIMS : $urandom_range(1, MAX_DIMS);
         volume = 1;
         for (int k = 0; k < MAX_DIMS; k++) begin
            if (k >= n_used) begin
               ext[k] = EXTENT_BITS'($urandom);
            end else begin
               case ($urandom_range(0, 31))
                  0:       ext[k] = '1;
                  1, 2:    ext[k] = EXTENT_BITS'($urandom_range(6, 4095));
                  default: ext[k] = EXTENT_BITS'($urandom_range(1, 5));
               endcase
            end
            axis_of[k] = k;
         end
         for (int k = n_used - 1; k > 0; k--) begin
            pick          = $urandom_range(0, k);
            tmp           = axis_of[k];
            axis_of[k]    = axis_of[pick];
            axis_of[pick] = tmp;
         end
         order = AXIS_ORDER_BITS'($urandom);
         for (int k = 0; k < n_used; k++) begin
            order[AXIS_BITS*k +: AXIS_BITS] = AXIS_BITS'(axis_of[k]);
         end
         dims = COUNT_BITS'(n_used);

         if (roll < 6) begin
            // unmapped register index: layout and counter must stay as they are
            wait_idle();
            csr_wr_en   <= 1'b1;
            csr_index   <= CSR_INDEX_BITS'(REG_AXIS_ORDER + $urandom_range(1, 2));
            csr_wr_data <= CSR_DATA_BITS'($urandom);
            @(posedge clock);
            csr_wr_en <= 1'b0;
            send_elems($urandom_range(4, 24));
         end else begin
            if (roll < 12) begin
               dims = COUNT_BITS'($urandom_range(MAX_DIMS + 1, 7));
            end else if (roll < 18) begin
               ext[$urandom_range(0, n_used - 1)] = '0;
            end else if (roll < 26 && n_used > 1) begin
               pick  = $urandom_range(0, n_used - 1);
               other = (pick + $urandom_range(1, n_used - 1)) % n_used;
               order[AXIS_BITS*pick +: AXIS_BITS] = order[AXIS_BITS*other +: AXIS_BITS];
            end else if (roll >= 26 && roll < 31) begin
               order[AXIS_BITS*$urandom_range(0, n_used - 1) +: AXIS_BITS] =
                  AXIS_BITS'($urandom_range(n_used, 7));
            end else if (roll >= 31 && roll < 35) begin
               dims = '0;
            end else if (roll >= 35 && roll < 40) begin
               dims  = COUNT_BITS'($urandom);
               ext   = PROD_BITS'({$urandom, $urandom});
               order = AXIS_ORDER_BITS'($urandom);
            end
            for (int k = 0; k < n_used; k++) volume *= ext[k];
            if (volume <= 48) begin
               n_elems = int'(volume) * $urandom_range(1, 2) + $urandom_range(1, 4);
            end else begin
               n_elems = $urandom_range(8, 40);
            end
            program_layout(dims, ext, order);
            send_elems(n_elems);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("%0d elements sent, %0d results checked over %0d tensor layouts",
               elems_sent, elems_predicted, layouts_applied);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
